// ----- hw/rtl/msc_pkg.sv -----
package msc_pkg;

    localparam int NUM_MOTORS_DEF = 9;
    localparam int TIME_BITS_DEF  = 32;
    localparam int QUEUE_DEPTH    = 2;
    localparam int CFG_IDX_W      = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_PRESENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_REVERSE = 2'd1;

    localparam logic [3:0] CMD_SET     = 4'd0;
    localparam logic [3:0] CMD_SIGNED  = 4'd1;
    localparam logic [3:0] CMD_CHANGE  = 4'd2;
    localparam logic [3:0] CMD_STANDBY = 4'd3;
    localparam logic [3:0] CMD_BRAKE   = 4'd4;
    localparam logic [3:0] CMD_RDFAULT = 4'd5;
    localparam logic [3:0] CMD_CLFAULT = 4'd6;
    localparam logic [3:0] CMD_RAMP    = 4'd7;
    localparam logic [3:0] CMD_TICK    = 4'd8;

    localparam logic [1:0] DIR_REV = 2'd1;
    localparam logic [1:0] DIR_FWD = 2'd2;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_BADID  = 2'd1;
    localparam logic [1:0] ST_BADDIR = 2'd2;

    localparam logic [1:0] ACC_NONE  = 2'd0;
    localparam logic [1:0] ACC_WRITE = 2'd1;
    localparam logic [1:0] ACC_READ  = 2'd2;

    localparam logic [7:0] BASE_ADDR    = 8'hC0;
    localparam logic [7:0] CLEAR_BYTE   = 8'h80;
    localparam logic [7:0] MODE_STANDBY = 8'h00;
    localparam logic [7:0] MODE_BRAKE   = 8'h03;
    localparam logic [6:0] MAX_SPEED    = 7'd63;
    localparam logic [6:0] MIN_SPEED    = 7'd6;

    typedef struct packed {
        logic [3:0]         cmd;
        logic [3:0]         motor;
        logic [1:0]         direction;
        logic [7:0]         magnitude;
        logic signed [7:0]  signed_value;
        logic [31:0]        duration;
    } msc_in_t;

    typedef struct packed {
        logic [1:0] status;
        logic [1:0] access;
        logic [7:0] device_address;
        logic       sub_address;
        logic [7:0] write_byte;
        logic       last;
    } msc_out_t;

    typedef enum logic [2:0] {
        CL_EXEC,
        CL_TICK,
        CL_UNKNOWN,
        CL_BADID,
        CL_BADDIR
    } msc_class_t;

    typedef struct packed {
        msc_in_t    data;
        msc_class_t cls;
    } msc_q_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_SCAN,
        BK_DIV,
        BK_APPLY
    } msc_bk_state_t;

    typedef enum logic [1:0] {
        OP_SETDM,
        OP_SETSV,
        OP_CHG,
        OP_STBY
    } msc_op_t;

endpackage

// ----- hw/rtl/multi_motor_speed_command_unit.sv -----
// A plain command passes the input queue and the output register before
// its result appears. A tick skips idle motors, finishes ramps that end
// within it, and steps the others (multiply, then a bit-serial divide).
// Throughput: one plain command per cycle unless a tick or out_ready stall
// holds it; ticks are bounded by the divider. Reset: asynchronous active low;
// speeds, targets and ramps clear, all motors present, none reversed.
module multi_motor_speed_command_unit #(
    parameter int NUM_MOTORS = msc_pkg::NUM_MOTORS_DEF,
    parameter int TIME_BITS  = msc_pkg::TIME_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  msc_pkg::msc_in_t                  in_data,
    output logic                              out_valid,
    input  logic                              out_ready,
    output msc_pkg::msc_out_t                 out_data,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [msc_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [NUM_MOTORS-1:0]             cfg_data
);
    import msc_pkg::*;

    logic [NUM_MOTORS-1:0] present_reg;
    logic [NUM_MOTORS-1:0] reverse_reg;
    logic                  head_valid;
    msc_q_t                head;
    logic                  pop;

    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            present_reg <= '1;
            reverse_reg <= '0;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == CFG_PRESENT)
            begin
                present_reg <= cfg_data;
            end
            else if (cfg_index == CFG_REVERSE)
            begin
                reverse_reg <= cfg_data;
            end
        end
    end

    msc_front #(
        .NUM_MOTORS(NUM_MOTORS)
    ) u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_ready     (in_ready),
        .in_data      (in_data),
        .present_mask (present_reg),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop)
    );

    msc_back #(
        .NUM_MOTORS(NUM_MOTORS),
        .TIME_BITS (TIME_BITS)
    ) u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .head_valid   (head_valid),
        .head         (head),
        .pop          (pop),
        .present_mask (present_reg),
        .reverse_mask (reverse_reg),
        .out_valid    (out_valid),
        .out_ready    (out_ready),
        .out_data     (out_data)
    );

    a_cfg_present: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_index == CFG_PRESENT |=> present_reg == $past(cfg_data))
        else $error("present mask write lost");

    a_no_access_no_addr: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.access == ACC_NONE |-> out_data.device_address == 8'd0)
        else $error("address without access");

    a_err_no_access: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.status != ST_OK |-> out_data.access == ACC_NONE)
        else $error("access on error beat");

    a_pop_needs_head: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> head_valid)
        else $error("pop from empty queue");

endmodule

// ----- hw/rtl/msc_front.sv -----
module msc_front #(
    parameter int NUM_MOTORS = msc_pkg::NUM_MOTORS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  msc_pkg::msc_in_t      in_data,
    input  logic [NUM_MOTORS-1:0] present_mask,
    output logic                  head_valid,
    output msc_pkg::msc_q_t       head,
    input  logic                  pop
);
    import msc_pkg::*;

    localparam int MW  = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int QPW = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCW = $clog2(QUEUE_DEPTH + 1);

    msc_q_t           q_reg [QUEUE_DEPTH];
    logic [QPW-1:0]   wr_reg, wr_next, rd_reg, rd_next;
    logic [QCW-1:0]   cnt_reg, cnt_next;
    msc_class_t       cls;
    logic             push;
    logic             id_bad;

    always_comb
    begin
        id_bad = ({1'b0, in_data.motor} >= 5'(NUM_MOTORS));
        if (!id_bad)
        begin
            id_bad = !present_mask[in_data.motor[MW-1:0]];
        end
        if (in_data.cmd == CMD_TICK)
        begin
            cls = CL_TICK;
        end
        else if (in_data.cmd > CMD_TICK)
        begin
            cls = CL_UNKNOWN;
        end
        else if (id_bad)
        begin
            cls = CL_BADID;
        end
        else if ((in_data.cmd == CMD_SET || in_data.cmd == CMD_RAMP) &&
                 in_data.direction != DIR_FWD && in_data.direction != DIR_REV)
        begin
            cls = CL_BADDIR;
        end
        else
        begin
            cls = CL_EXEC;
        end
    end

    assign in_ready   = (cnt_reg != QCW'(QUEUE_DEPTH));
    assign push       = in_valid && in_ready;
    assign head_valid = (cnt_reg != '0);
    assign head       = q_reg[rd_reg];

    always_comb
    begin
        wr_next  = wr_reg;
        rd_next  = rd_reg;
        cnt_next = cnt_reg;
        if (push)
        begin
            wr_next = (wr_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : wr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_next = (rd_reg == QPW'(QUEUE_DEPTH - 1)) ? '0 : rd_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            wr_reg  <= wr_next;
            rd_reg  <= rd_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            q_reg[wr_reg] <= '{data: in_data, cls: cls};
        end
    end

endmodule

// ----- hw/rtl/msc_back.sv -----
module msc_back #(
    parameter int NUM_MOTORS = msc_pkg::NUM_MOTORS_DEF,
    parameter int TIME_BITS  = msc_pkg::TIME_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  head_valid,
    input  msc_pkg::msc_q_t       head,
    output logic                  pop,
    input  logic [NUM_MOTORS-1:0] present_mask,
    input  logic [NUM_MOTORS-1:0] reverse_mask,
    output logic                  out_valid,
    input  logic                  out_ready,
    output msc_pkg::msc_out_t     out_data
);
    import msc_pkg::*;

    localparam int MW   = (NUM_MOTORS > 1) ? $clog2(NUM_MOTORS) : 1;
    localparam int CW   = $clog2(NUM_MOTORS + 1);
    localparam int TB   = TIME_BITS;
    localparam int PW   = TIME_BITS + 8;
    localparam int DCW  = $clog2(PW);

    function automatic logic [5:0] clamp_mag(input logic [7:0] v);
        logic [5:0] r;
        if (v == 8'd0)
        begin
            r = 6'd0;
        end
        else if (v < 8'(MIN_SPEED))
        begin
            r = 6'(MIN_SPEED);
        end
        else if (v > 8'(MAX_SPEED))
        begin
            r = 6'(MAX_SPEED);
        end
        else
        begin
            r = v[5:0];
        end
        return r;
    endfunction

    logic signed [6:0] spd_reg [NUM_MOTORS];
    logic signed [6:0] tgt_reg [NUM_MOTORS];
    logic [TB-1:0]     rem_reg [NUM_MOTORS];

    msc_bk_state_t     state_reg, state_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [TB-1:0]     t_reg, t_next;
    logic [PW-1:0]     dq_reg, dq_next;
    logic [TB-1:0]     r_reg, r_next;
    logic [DCW-1:0]    cnt_reg, cnt_next;
    logic              neg_reg, neg_next;
    logic              out_valid_reg;
    msc_out_t          out_data_reg;

    logic [MW-1:0]     sel_m;
    logic signed [6:0] cur_spd;
    logic [NUM_MOTORS-1:0] act;
    logic              later;
    logic              slot_free;

    msc_op_t           op_kind;
    logic [1:0]        op_dir;
    logic [7:0]        op_mag;
    logic signed [8:0] op_val;
    logic [7:0]        op_mode;
    logic signed [6:0] new_spd;
    logic [7:0]        op_byte;

    logic              emit;
    msc_out_t          res;
    logic              spd_we, tgt_we, rem_we;
    logic signed [6:0] tgt_wval;
    logic [TB-1:0]     rem_wval;
    logic signed [8:0] quot;
    logic [5:0]        ramp_c;

    assign sel_m     = (state_reg == BK_IDLE) ? head.data.motor[MW-1:0] : idx_reg[MW-1:0];
    assign cur_spd   = spd_reg[sel_m];
    assign slot_free = !out_valid_reg || out_ready;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign quot      = neg_reg ? -$signed(dq_reg[8:0]) : $signed(dq_reg[8:0]);
    assign ramp_c    = clamp_mag(head.data.magnitude);
    assign tgt_wval  = (head.data.direction == DIR_FWD) ? $signed({1'b0, ramp_c})
                                                        : -$signed({1'b0, ramp_c});

    always_comb
    begin
        later = 1'b0;
        for (int j = 0; j < NUM_MOTORS; j++)
        begin
            act[j] = present_mask[j] && (rem_reg[j] != '0);
            if (CW'(j) > idx_reg)
            begin
                later = later | act[j];
            end
        end
    end

    always_comb
    begin
        op_kind = OP_STBY;
        op_dir  = head.data.direction;
        op_mag  = head.data.magnitude;
        op_val  = 9'(head.data.signed_value);
        op_mode = MODE_STANDBY;
        case (state_reg)
            BK_IDLE:
            begin
                case (head.data.cmd)
                    CMD_SET:    op_kind = OP_SETDM;
                    CMD_SIGNED: op_kind = OP_SETSV;
                    CMD_CHANGE: op_kind = OP_CHG;
                    CMD_BRAKE:  op_mode = MODE_BRAKE;
                    default:    op_mode = MODE_STANDBY;
                endcase
            end
            BK_SCAN:
            begin
                op_kind = OP_SETSV;
                op_val  = 9'(tgt_reg[sel_m]);
            end
            BK_APPLY:
            begin
                op_kind = OP_CHG;
                op_val  = quot;
            end
            default: op_kind = OP_STBY;
        endcase
    end

    always_comb
    begin
        logic signed [9:0] s;
        logic signed [8:0] nv;
        logic [1:0]        d;
        logic [7:0]        mg;
        logic [5:0]        c;
        logic [1:0]        eff;
        logic              setp;
        new_spd = cur_spd;
        op_byte = 8'd0;
        d       = op_dir;
        mg      = op_mag;
        setp    = 1'b0;
        s       = 10'(op_val);
        nv      = -op_val;
        case (op_kind)
            OP_SETDM: setp = 1'b1;
            OP_SETSV:
            begin
                setp = 1'b1;
                d    = (op_val > 9'sd0) ? DIR_FWD : DIR_REV;
                mg   = (op_val > 9'sd0) ? op_val[7:0] : nv[7:0];
            end
            OP_CHG:
            begin
                s = 10'(cur_spd) + 10'(op_val);
                if (s > 10'sd63)
                begin
                    s = 10'sd63;
                end
                if (s < -10'sd63)
                begin
                    s = -10'sd63;
                end
                if (s >= 10'sd6 || s <= -10'sd6)
                begin
                    setp = 1'b1;
                    d    = (s > 10'sd0) ? DIR_FWD : DIR_REV;
                    mg   = (s > 10'sd0) ? s[7:0] : 8'(-s);
                end
                else
                begin
                    new_spd = s[6:0];
                end
            end
            OP_STBY:
            begin
                if (cur_spd >= 7'sd6 || cur_spd <= -7'sd6)
                begin
                    new_spd = 7'sd0;
                end
                op_byte = op_mode;
            end
            default: op_byte = 8'd0;
        endcase
        c   = clamp_mag(mg);
        eff = d;
        if (reverse_mask[sel_m])
        begin
            eff = (d == DIR_FWD) ? DIR_REV : DIR_FWD;
        end
        if (setp)
        begin
            new_spd = (d == DIR_FWD) ? $signed({1'b0, c}) : -$signed({1'b0, c});
            op_byte = (c == 6'd0) ? 8'd0 : {c, eff};
        end
    end

    always_comb
    begin
        logic signed [7:0] diff;
        logic [6:0]        absd;
        logic [TB:0]       rw;
        logic              qb;
        state_next = state_reg;
        idx_next   = idx_reg;
        t_next     = t_reg;
        dq_next    = dq_reg;
        r_next     = r_reg;
        cnt_next   = cnt_reg;
        neg_next   = neg_reg;
        pop        = 1'b0;
        emit       = 1'b0;
        res        = '0;
        spd_we     = 1'b0;
        tgt_we     = 1'b0;
        rem_we     = 1'b0;
        rem_wval   = '0;
        diff       = 8'(tgt_reg[sel_m]) - 8'(spd_reg[sel_m]);
        absd       = diff[7] ? 7'(-diff) : diff[6:0];
        rw         = {r_reg, dq_reg[PW-1]};
        qb         = (rw >= {1'b0, rem_reg[sel_m]});
        case (state_reg)
            BK_IDLE:
            begin
                if (head_valid && head.cls == CL_TICK)
                begin
                    pop        = 1'b1;
                    t_next     = head.data.duration[TB-1:0];
                    idx_next   = '0;
                    state_next = BK_SCAN;
                end
                else if (head_valid && slot_free)
                begin
                    pop      = 1'b1;
                    emit     = 1'b1;
                    res.last = 1'b1;
                    case (head.cls)
                        CL_BADID:  res.status = ST_BADID;
                        CL_BADDIR: res.status = ST_BADDIR;
                        CL_EXEC:
                        begin
                            res.device_address = BASE_ADDR + 8'({sel_m, 1'b0});
                            res.access         = ACC_WRITE;
                            case (head.data.cmd)
                                CMD_RDFAULT:
                                begin
                                    res.access      = ACC_READ;
                                    res.sub_address = 1'b1;
                                end
                                CMD_CLFAULT:
                                begin
                                    res.sub_address = 1'b1;
                                    res.write_byte  = CLEAR_BYTE;
                                end
                                CMD_RAMP:
                                begin
                                    res.access         = ACC_NONE;
                                    res.device_address = 8'd0;
                                    tgt_we             = 1'b1;
                                    rem_we             = 1'b1;
                                    rem_wval           = head.data.duration[TB-1:0];
                                end
                                default:
                                begin
                                    res.write_byte = op_byte;
                                    spd_we         = 1'b1;
                                    rem_we         = 1'b1;
                                end
                            endcase
                        end
                        default: res.status = ST_OK;
                    endcase
                end
            end
            BK_SCAN:
            begin
                if (idx_reg == CW'(NUM_MOTORS))
                begin
                    state_next = BK_IDLE;
                end
                else if (!act[sel_m])
                begin
                    idx_next = idx_reg + 1'b1;
                end
                else if (rem_reg[sel_m] > t_reg)
                begin
                    dq_next    = absd * t_reg;
                    neg_next   = diff[7];
                    r_next     = '0;
                    cnt_next   = '0;
                    state_next = BK_DIV;
                end
                else if (slot_free)
                begin
                    spd_we   = 1'b1;
                    rem_we   = 1'b1;
                    emit     = 1'b1;
                    idx_next = idx_reg + 1'b1;
                end
            end
            BK_DIV:
            begin
                r_next   = qb ? TB'(rw - {1'b0, rem_reg[sel_m]}) : rw[TB-1:0];
                dq_next  = {dq_reg[PW-2:0], qb};
                cnt_next = cnt_reg + 1'b1;
                if (cnt_reg == DCW'(PW - 1))
                begin
                    state_next = BK_APPLY;
                end
            end
            BK_APPLY:
            begin
                if (slot_free)
                begin
                    spd_we     = 1'b1;
                    rem_we     = 1'b1;
                    rem_wval   = rem_reg[sel_m] - t_reg;
                    emit       = 1'b1;
                    idx_next   = idx_reg + 1'b1;
                    state_next = BK_SCAN;
                end
            end
            default: state_next = BK_IDLE;
        endcase
        if (state_reg == BK_SCAN || state_reg == BK_APPLY)
        begin
            res.access         = ACC_WRITE;
            res.device_address = BASE_ADDR + 8'({sel_m, 1'b0});
            res.write_byte     = op_byte;
            res.last           = !later;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < NUM_MOTORS; i++)
            begin
                spd_reg[i] <= '0;
                tgt_reg[i] <= '0;
                rem_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            if (spd_we)
            begin
                spd_reg[sel_m] <= new_spd;
            end
            if (tgt_we)
            begin
                tgt_reg[sel_m] <= tgt_wval;
            end
            if (rem_we)
            begin
                rem_reg[sel_m] <= rem_wval;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        t_reg   <= t_next;
        dq_reg  <= dq_next;
        r_reg   <= r_next;
        cnt_reg <= cnt_next;
        neg_reg <= neg_next;
        if (emit)
        begin
            out_data_reg <= res;
        end
    end

endmodule
